/* sv/gest_pkg.sv */
// shared types, constants and helpers for the extrusion segment tracker
package gest_pkg;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned PROD_W = 2 * POS_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned TOT_W  = 48;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned STEP_W = $clog2(POS_W);
  localparam int unsigned REM_W  = POS_W + 1;

  // 0.001 mm in q16.16 is 65.536 lsb, so an advance above 65 extrudes
  localparam logic signed [POS_W:0] E_THRESHOLD = (POS_W + 1)'(65);

  typedef enum logic [2:0] {
    ACT_MOVE    = 3'd0,
    ACT_ABS_XYZ = 3'd1,
    ACT_REL_XYZ = 3'd2,
    ACT_ABS_E   = 3'd3,
    ACT_REL_E   = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_SQ,
    S_ADD1,
    S_ADD2,
    S_ROOT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]              action;
    logic                    has_x;
    logic                    has_y;
    logic                    has_z;
    logic                    has_e;
    logic signed [POS_W-1:0] x_word;
    logic signed [POS_W-1:0] y_word;
    logic signed [POS_W-1:0] z_word;
    logic signed [POS_W-1:0] e_word;
  } gest_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
    logic signed [POS_W-1:0] start_z;
    logic signed [POS_W-1:0] end_x;
    logic signed [POS_W-1:0] end_y;
    logic signed [POS_W-1:0] end_z;
    logic [POS_W-1:0]        segment_length;
    logic [TOT_W-1:0]        length_total;
    logic [CNT_W-1:0]        segment_count;
  } gest_out_t;

  // absolute load or saturating relative add of one coordinate
  function automatic logic signed [POS_W-1:0] upd_axis(
    input logic signed [POS_W-1:0] old,
    input logic                    present,
    input logic                    absolute,
    input logic signed [POS_W-1:0] word
  );
    logic signed [POS_W:0] sum;
    logic signed [POS_W-1:0] res;
    sum = {old[POS_W-1], old} + {word[POS_W-1], word};
    if (!present) begin
      res = old;
    end else if (absolute) begin
      res = word;
    end else if (sum[POS_W] != sum[POS_W-1]) begin
      res = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      res = sum[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

/* sv/gest_sqr.sv */
// bit-serial squarer of one axis difference, one multiplier bit per cycle
module gest_sqr import gest_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [POS_W-1:0] a_i,
  input  logic signed [POS_W-1:0] b_i,
  output logic                    done_o,
  output logic [PROD_W-1:0]       prod_o
);

  logic signed [POS_W:0] diff;
  logic [POS_W:0]        mag_w;
  logic [POS_W-1:0]      mag;
  logic [POS_W:0]        add;
  logic [POS_W-1:0]      mcand_q;
  logic [PROD_W-1:0]     prod_q, prod_d;
  logic [STEP_W-1:0]     cnt_q;
  logic                  busy_q, done_q;

  assign diff  = {b_i[POS_W-1], b_i} - {a_i[POS_W-1], a_i};
  assign mag_w = diff[POS_W] ? (~diff + 1'b1) : diff;
  assign mag   = mag_w[POS_W-1:0];

  // add the multiplicand when the low multiplier bit is set, then shift right
  assign add    = {1'b0, prod_q[PROD_W-1:POS_W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
  assign prod_d = {add, prod_q[POS_W-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mag;
      prod_q  <= {{POS_W{1'b0}}, mag};
    end else if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

/* sv/gest_isqrt.sv */
// digit-by-digit integer square root, two radicand bits per cycle
module gest_isqrt import gest_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] rad_i,
  output logic              done_o,
  output logic [POS_W-1:0]  root_o
);

  logic [PROD_W-1:0] rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [POS_W-1:0]  root_q;
  logic [REM_W+1:0]  rem_sh, trial, diff;
  logic              take;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;

  assign rem_sh = {rem_q, rad_q[PROD_W-1:PROD_W-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign take   = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[PROD_W-3:0], 2'b00};
      if (take) begin
        rem_q  <= diff[REM_W-1:0];
        root_q <= {root_q[POS_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[REM_W-1:0];
        root_q <= {root_q[POS_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* sv/gcode_extrusion_segment_tracker_top.sv */
// top level of the g-code extrusion segment tracker
// usage:
//   in channel (in_valid_i / in_ready_o / in_data_i) takes one decoded command
//   per beat: a mode change (g90, g91, m82, m83) or a straight move.
//   out channel (out_valid_o / out_ready_i / out_data_o) gives one segment beat
//   for each move whose extruder advance is above 0.001 mm.
// sequence:
//   a mode command or a non-extruding move is captured, then executed.
//   an extruding move raises out_valid_o after execute and load, the bit-serial
//   squarers of the three axis differences running side by side, two adds of
//   the squares, root start and the two-bits-per-cycle square root, once the
//   output register is free.
//   the next command is taken only once the segment is in the output register.
//   in_ready_o is high only while the sequencer is idle.
// reset:
//   absolute mode for xyz and extruder, all positions, the length total and
//   the segment count cleared; no beat pending on either side.
// stall:
//   a finished segment sits in the output register until taken; a new command
//   is still accepted meanwhile, and only a second segment waits for it.
module gcode_extrusion_segment_tracker_top import gest_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gest_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output gest_out_t out_data_o
);

  state_e state_q, state_d;

  // command being worked on
  gest_in_t hold_q;

  // tracker state
  logic                    xyz_abs_q, ext_abs_q;
  logic signed [POS_W-1:0] pos_q [3];
  logic signed [POS_W-1:0] epos_q;
  logic [TOT_W-1:0]        acc_q;
  logic [CNT_W-1:0]        cnt_q;

  // segment under computation
  logic signed [POS_W-1:0] seg_start_q [3];
  logic signed [POS_W-1:0] seg_end_q [3];
  logic [SUM_W-1:0]        sum_q;

  // sticky flag: root result ready for the current segment
  logic rt_ready_q;

  // output register
  gest_out_t out_q;
  logic      out_valid_q;

  // next positions of a move
  logic signed [POS_W-1:0] np [3];
  logic signed [POS_W-1:0] ne;
  logic signed [POS_W:0]   adv;
  logic                    extrude;

  // sequencer strobes
  logic in_take, do_exec, lane_start, do_add1, do_add2, root_start, out_load;

  logic                    sq_done [3];
  logic [PROD_W-1:0]       sq_prod [3];
  logic                    rt_done;
  logic [POS_W-1:0]        rt_root;

  logic [POS_W-1:0] len;
  logic [TOT_W:0]   tot;
  logic [TOT_W-1:0] acc_new;
  logic [CNT_W-1:0] cnt_new;

  assign np[0] = upd_axis(pos_q[0], hold_q.has_x, xyz_abs_q, hold_q.x_word);
  assign np[1] = upd_axis(pos_q[1], hold_q.has_y, xyz_abs_q, hold_q.y_word);
  assign np[2] = upd_axis(pos_q[2], hold_q.has_z, xyz_abs_q, hold_q.z_word);
  assign ne    = upd_axis(epos_q, hold_q.has_e, ext_abs_q, hold_q.e_word);

  // advance measured on the stored, saturated extruder values
  assign adv     = {ne[POS_W-1], ne} - {epos_q[POS_W-1], epos_q};
  assign extrude = adv > E_THRESHOLD;

  // a sum of squares at or above 2^64 saturates the length
  assign len     = (|sum_q[SUM_W-1:PROD_W]) ? '1 : rt_root;
  assign tot     = {1'b0, acc_q} + {{(TOT_W + 1 - POS_W){1'b0}}, len};
  assign acc_new = tot[TOT_W] ? '1 : tot[TOT_W-1:0];
  assign cnt_new = (&cnt_q) ? cnt_q : cnt_q + 1'b1;

  // sequencer
  always_comb begin
    state_d    = state_q;
    in_take    = 1'b0;
    do_exec    = 1'b0;
    lane_start = 1'b0;
    do_add1    = 1'b0;
    do_add2    = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_take = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        do_exec = 1'b1;
        if (hold_q.action == ACT_MOVE && extrude) begin
          state_d = S_LOAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_LOAD: begin
        lane_start = 1'b1;
        state_d    = S_SQ;
      end
      S_SQ: begin
        if (sq_done[0] && sq_done[1] && sq_done[2]) begin
          state_d = S_ADD1;
        end
      end
      S_ADD1: begin
        do_add1 = 1'b1;
        state_d = S_ADD2;
      end
      S_ADD2: begin
        do_add2 = 1'b1;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        root_start = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        // wait for the root, then for a free output register
        if ((rt_ready_q || rt_done) && (!out_valid_q || out_ready_i)) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      xyz_abs_q   <= 1'b1;
      ext_abs_q   <= 1'b1;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      pos_q[2]    <= '0;
      epos_q      <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      rt_ready_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_exec) begin
        unique case (hold_q.action)
          ACT_ABS_XYZ: xyz_abs_q <= 1'b1;
          ACT_REL_XYZ: xyz_abs_q <= 1'b0;
          ACT_ABS_E:   ext_abs_q <= 1'b1;
          ACT_REL_E:   ext_abs_q <= 1'b0;
          ACT_MOVE: begin
            pos_q[0] <= np[0];
            pos_q[1] <= np[1];
            pos_q[2] <= np[2];
            epos_q   <= ne;
          end
          default: ;
        endcase
      end
      if (root_start) begin
        rt_ready_q <= 1'b0;
      end else if (rt_done) begin
        rt_ready_q <= 1'b1;
      end
      if (out_load) begin
        acc_q       <= acc_new;
        cnt_q       <= cnt_new;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      hold_q <= in_data_i;
    end
    if (do_exec) begin
      for (int i = 0; i < 3; i++) begin
        seg_start_q[i] <= pos_q[i];
        seg_end_q[i]   <= np[i];
      end
    end
    if (do_add1) begin
      sum_q <= {2'b00, sq_prod[0]} + {2'b00, sq_prod[1]};
    end else if (do_add2) begin
      sum_q <= sum_q + {2'b00, sq_prod[2]};
    end
    if (out_load) begin
      out_q.start_x        <= seg_start_q[0];
      out_q.start_y        <= seg_start_q[1];
      out_q.start_z        <= seg_start_q[2];
      out_q.end_x          <= seg_end_q[0];
      out_q.end_y          <= seg_end_q[1];
      out_q.end_z          <= seg_end_q[2];
      out_q.segment_length <= len;
      out_q.length_total   <= acc_new;
      out_q.segment_count  <= cnt_new;
    end
  end

  // one squarer lane per axis, all started together
  for (genvar g = 0; g < 3; g++) begin : g_lane
    gest_sqr u_sqr (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (lane_start),
      .a_i     (seg_start_q[g]),
      .b_i     (seg_end_q[g]),
      .done_o  (sq_done[g]),
      .prod_o  (sq_prod[g])
    );
  end

  gest_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (sum_q[PROD_W-1:0]),
    .done_o  (rt_done),
    .root_o  (rt_root)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sv/gest_checker.sv */
// port-level checks of the segment tracker, bound to the top level
module gest_checker import gest_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input gest_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input gest_out_t out_data_o
);

  // a waiting command beat holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("command beat dropped or changed while waiting");

  // a pending segment beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("segment beat dropped or changed while stalled");

  // input ready drops right after a taken command beat
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a command beat");

  // a new segment only appears from the busy sequencer
  a_seg_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("segment beat appeared while idle");

  // the running total covers this segment and the count is nonzero
  a_total_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.segment_count != '0) &&
      (out_data_o.length_total >= {{(TOT_W - POS_W){1'b0}}, out_data_o.segment_length}))
    else $error("segment total or count inconsistent");

endmodule

bind gcode_extrusion_segment_tracker_top gest_checker u_gest_checker (.*);

/* dv/gcode_extrusion_segment_tracker_top_test.sv */
// self-checking testbench for the g-code extrusion segment tracker top level
module gcode_extrusion_segment_tracker_top_test;
  import gest_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RAND_ITEMS   = 450;
  localparam int unsigned PHASE_LEN    = 150;
  localparam int unsigned E_MIN_ADV    = 66;  // smallest extruder rise that lays down filament
  localparam longint      E_DEAD_BAND  = 65;

  // action codes the block must ignore
  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;

  localparam logic signed [31:0] MM    = 32'sh0001_0000;
  localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] P_MIN = 32'sh8000_0000;

  // one directed command; lit rows carry a hand-computed segment
  typedef struct {
    gest_in_t  cmd;
    bit        lit;
    gest_out_t seg;
  } dir_row_t;

  localparam int unsigned N_DIR = 26;

  dir_row_t dir_rows [N_DIR] = '{
    // first extrusion after reset: 1 mm along x
    '{'{ACT_MOVE, 1'b1, 1'b0, 1'b0, 1'b1, MM, 32'sh0, 32'sh0, 32'sd66}, 1'b1,
      '{32'sh0, 32'sh0, 32'sh0, MM, 32'sh0, 32'sh0, 32'h0001_0000, 48'h1_0000, 32'd1}},
    // advance of exactly 65 lsb stays under the threshold, x word not flagged
    '{'{ACT_MOVE, 1'b0, 1'b0, 1'b0, 1'b1, P_MAX, 32'sh0, 32'sh0, 32'sd131}, 1'b0, '0},
    // 3-4-5 triangle, 5 mm segment
    '{'{ACT_MOVE, 1'b1, 1'b1, 1'b0, 1'b1, 32'sh0004_0000, 32'sh0004_0000, 32'sh0,
        32'sd200}, 1'b1,
      '{MM, 32'sh0, 32'sh0, 32'sh0004_0000, 32'sh0004_0000, 32'sh0, 32'h0005_0000,
        48'h6_0000, 32'd2}},
    // corner to corner of the whole space: the second one is too long to represent
    '{'{ACT_MOVE, 1'b1, 1'b1, 1'b1, 1'b1, P_MAX, P_MAX, P_MAX, 32'sh1000}, 1'b0, '0},
    '{'{ACT_MOVE, 1'b1, 1'b1, 1'b1, 1'b1, P_MIN, P_MIN, P_MIN, 32'sh2000}, 1'b0, '0},
    // extrude in place, zero length
    '{'{ACT_MOVE, 1'b0, 1'b0, 1'b0, 1'b1, 32'sh0, 32'sh0, 32'sh0, P_MAX}, 1'b0, '0},
    // m83, words ignored
    '{'{ACT_REL_E, 1'b1, 1'b1, 1'b1, 1'b1, P_MAX, P_MIN, P_MAX, P_MIN}, 1'b0, '0},
    // relative extruder add clips at the top, so no advance
    '{'{ACT_MOVE, 1'b0, 1'b0, 1'b0, 1'b1, 32'sh0, 32'sh0, 32'sh0, P_MAX}, 1'b0, '0},
    // retract
    '{'{ACT_MOVE, 1'b0, 1'b0, 1'b0, 1'b1, 32'sh0, 32'sh0, 32'sh0, -32'sd5}, 1'b0, '0},
    // g91
    '{'{ACT_REL_XYZ, 1'b1, 1'b1, 1'b1, 1'b1, P_MIN, P_MIN, P_MIN, P_MAX}, 1'b0, '0},
    // x clips low, y lands on -1 lsb, extruder clips high leaving a 5 lsb rise
    '{'{ACT_MOVE, 1'b1, 1'b1, 1'b0, 1'b1, P_MIN, P_MAX, 32'sh0, 32'sd66}, 1'b0, '0},
    '{'{ACT_MOVE, 1'b0, 1'b0, 1'b1, 1'b1, 32'sh0, 32'sh0, P_MAX, 32'sh0}, 1'b0, '0},
    // m82, then an absolute extruder drop
    '{'{ACT_ABS_E, 1'b0, 1'b0, 1'b0, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, 1'b0, '0},
    '{'{ACT_MOVE, 1'b0, 1'b0, 1'b0, 1'b1, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, 1'b0, '0},
    '{'{ACT_REL_E, 1'b0, 1'b0, 1'b0, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0}, 1'b0, '0},
    // relative move with relative extrusion, then one lsb short
    '{'{ACT_MOVE, 1'b1, 1'b0, 1'b0, 1'b1, MM, 32'sh0, 32'sh0, 32'sd66}, 1'b0, '0},
    '{'{ACT_MOVE, 1'b0, 1'b0, 1'b0, 1'b1, 32'sh0, 32'sh0, 32'sh0, 32'sd65}, 1'b0, '0},
    // move with no words at all
    '{'{ACT_MOVE, 1'b0, 1'b0, 1'b0, 1'b0, P_MAX, P_MAX, P_MAX, P_MAX}, 1'b0, '0},
    // unused action codes
    '{'{ACT_RSVD5, 1'b1, 1'b1, 1'b1, 1'b1, P_MAX, P_MIN, MM, P_MAX}, 1'b0, '0},
    '{'{ACT_RSVD6, 1'b1, 1'b1, 1'b1, 1'b1, P_MIN, P_MAX, MM, P_MAX}, 1'b0, '0},
    '{'{ACT_RSVD7, 1'b1, 1'b1, 1'b1, 1'b1, MM, MM, MM, P_MAX}, 1'b0, '0},
    // g90, absolute x back home while extruding relative
    '{'{ACT_ABS_XYZ, 1'b1, 1'b1, 1'b1, 1'b1, P_MAX, P_MAX, P_MAX, P_MAX}, 1'b0, '0},
    '{'{ACT_MOVE, 1'b1, 1'b0, 1'b0, 1'b1, 32'sh0, 32'sh0, 32'sh0, 32'sd1000}, 1'b0, '0},
    // two big retracts: the second clips at the bottom
    '{'{ACT_MOVE, 1'b0, 1'b0, 1'b0, 1'b1, 32'sh0, 32'sh0, 32'sh0, P_MIN}, 1'b0, '0},
    '{'{ACT_MOVE, 1'b0, 1'b0, 1'b0, 1'b1, 32'sh0, 32'sh0, 32'sh0, P_MIN}, 1'b0, '0},
    // huge advance from the bottom with a 3-axis move
    '{'{ACT_MOVE, 1'b1, 1'b1, 1'b1, 1'b1, -32'sh0003_0000, 32'sh0002_0000, 32'sh0007_0000,
        P_MAX}, 1'b0, '0}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  gest_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  gest_out_t out_data_o;

  // tracker state as the testbench sees it
  bit                 xyz_abs;
  bit                 ext_abs;
  logic signed [31:0] pos [3];
  logic signed [31:0] ext_pos;
  logic [47:0]        len_total;
  logic [31:0]        seg_cnt;

  gest_out_t   seg_q [$];  // segments still owed by the block
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned err_cnt;
  int unsigned cmd_cnt;
  int unsigned seg_beats;
  int unsigned long_segs;
  int unsigned cycle_cnt = 0;

  gcode_extrusion_segment_tracker_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // absolute load, or relative add clipped to the signed 32-bit range
  function automatic logic signed [31:0] next_coord(logic signed [31:0] old, logic present,
                                                    logic absolute, logic signed [31:0] word);
    longint s;
    s = longint'(old) + longint'(word);
    if (!present) return old;
    if (absolute) return word;
    if (s > longint'(P_MAX)) return P_MAX;
    if (s < longint'(P_MIN)) return P_MIN;
    return 32'(s);
  endfunction

  function automatic logic [31:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root[31:0];
  endfunction

  // apply one accepted command, and hand back the segment it lays down if any
  task automatic track_command(input gest_in_t c, output bit emit, output gest_out_t seg);
    logic signed [31:0] np [3];
    logic signed [31:0] words [3];
    logic               has [3];
    logic signed [31:0] ne;
    logic [65:0]        sq_sum;
    logic [63:0]        mag;
    logic [31:0]        seg_len;
    logic [48:0]        tot;
    longint             d;
    emit = 1'b0;
    seg  = '0;
    case (c.action)
      ACT_ABS_XYZ: xyz_abs = 1'b1;
      ACT_REL_XYZ: xyz_abs = 1'b0;
      ACT_ABS_E:   ext_abs = 1'b1;
      ACT_REL_E:   ext_abs = 1'b0;
      ACT_MOVE: begin
        words = '{c.x_word, c.y_word, c.z_word};
        has   = '{c.has_x, c.has_y, c.has_z};
        for (int i = 0; i < 3; i++) np[i] = next_coord(pos[i], has[i], xyz_abs, words[i]);
        ne = next_coord(ext_pos, c.has_e, ext_abs, c.e_word);
        if (longint'(ne) - longint'(ext_pos) > E_DEAD_BAND) begin
          // squared distance kept wide enough to see a length past 32 bits
          sq_sum = '0;
          for (int i = 0; i < 3; i++) begin
            d      = longint'(np[i]) - longint'(pos[i]);
            mag    = (d < 0) ? 64'(-d) : 64'(d);
            sq_sum = sq_sum + 66'(mag * mag);
          end
          seg_len   = (sq_sum[65:64] != 2'b00) ? '1 : floor_sqrt(sq_sum[63:0]);
          tot       = {1'b0, len_total} + 49'(seg_len);
          len_total = tot[48] ? '1 : tot[47:0];
          if (seg_cnt != '1) seg_cnt++;
          if (seg_len == '1) long_segs++;
          seg  = '{pos[0], pos[1], pos[2], np[0], np[1], np[2], seg_len, len_total, seg_cnt};
          emit = 1'b1;
        end
        pos     = np;
        ext_pos = ne;
      end
      default: ;
    endcase
  endtask

  // coordinate words: mostly a few cm either side of zero, sometimes the edges
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return P_MAX;
      1:       return P_MIN;
      2:       return 32'($urandom);
      3:       return '0;
      default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  // mostly extruding moves shaped from the current extruder state, some mode
  // changes, some ignored codes and some moves with arbitrary extruder words
  function automatic gest_in_t random_cmd();
    gest_in_t           c;
    int unsigned        pick;
    logic signed [31:0] adv;
    pick      = $urandom_range(0, 99);
    c.action  = ACT_MOVE;
    c.has_x   = ($urandom_range(0, 3) != 0);
    c.has_y   = ($urandom_range(0, 3) != 0);
    c.has_z   = ($urandom_range(0, 3) != 0);
    c.has_e   = 1'($urandom_range(0, 1));
    c.x_word  = pick_word();
    c.y_word  = pick_word();
    c.z_word  = pick_word();
    c.e_word  = pick_word();
    if (pick < 8) begin
      c.action = 3'($urandom_range(ACT_ABS_XYZ, ACT_REL_E));
    end else if (pick < 11) begin
      c.action = 3'($urandom_range(ACT_RSVD5, ACT_RSVD7));
    end else if (pick < 82) begin
      adv      = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(E_MIN_ADV, 32'h0100_0000))
                                             : 32'($urandom_range(E_MIN_ADV, 4000));
      c.has_e  = 1'b1;
      c.e_word = ext_abs ? ext_pos + adv : adv;
    end
    return c;
  endfunction

  // one input beat; valid stays up from one beat to the next unless we idle
  task automatic send_cmd(input gest_in_t c, output bit emit, output gest_out_t seg);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cmd_cnt++;
    track_command(c, emit, seg);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h, output beat %0d", what, got, want,
             seg_beats);
    err_cnt++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_segment(input gest_out_t got);
    gest_out_t want;
    seg_beats++;
    if (seg_q.size() == 0) begin
      report_mismatch("segment beat with none pending", 64'(got.segment_count), '0);
      return;
    end
    want = seg_q.pop_front();
    check_field("start_x", 64'(got.start_x), 64'(want.start_x));
    check_field("start_y", 64'(got.start_y), 64'(want.start_y));
    check_field("start_z", 64'(got.start_z), 64'(want.start_z));
    check_field("end_x", 64'(got.end_x), 64'(want.end_x));
    check_field("end_y", 64'(got.end_y), 64'(want.end_y));
    check_field("end_z", 64'(got.end_z), 64'(want.end_z));
    check_field("segment_length", 64'(got.segment_length), 64'(want.segment_length));
    check_field("length_total", 64'(got.length_total), 64'(want.length_total));
    check_field("segment_count", 64'(got.segment_count), 64'(want.segment_count));
  endtask

  // output side: check every accepted beat, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_segment(out_data_o);
    out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d segments still pending", cycle_cnt,
               seg_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    gest_in_t  c;
    gest_out_t seg;
    bit        emit;
    xyz_abs      = 1'b1;
    ext_abs      = 1'b1;
    pos          = '{32'sh0, 32'sh0, 32'sh0};
    ext_pos      = '0;
    len_total    = '0;
    seg_cnt      = '0;
    err_cnt      = 0;
    cmd_cnt      = 0;
    seg_beats    = 0;
    long_segs    = 0;
    snd_idle_pct = 30;
    rcv_idle_pct = 73;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; hand-computed rows override the tracker's own segment
    foreach (dir_rows[r]) begin
      send_cmd(dir_rows[r].cmd, emit, seg);
      if (dir_rows[r].lit) seg_q = {seg_q, dir_rows[r].seg};
      else if (emit) seg_q = {seg_q, seg};
    end

    // random stream in three idle mixes
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (n == PHASE_LEN) begin
        snd_idle_pct = 73;
        rcv_idle_pct = 30;
        // hold off until the block has delivered everything it owes
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (seg_q.size() != 0) @(posedge clk_i);
      end else if (n == 2 * PHASE_LEN) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      c = random_cmd();
      send_cmd(c, emit, seg);
      if (emit) seg_q = {seg_q, seg};
    end
    in_valid_i <= 1'b0;

    while (seg_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d commands (%0d from the table), checked %0d segment beats, %0d of them",
             cmd_cnt, N_DIR, seg_beats, long_segs);
    $display("  at the length ceiling; idle mixes 30/73, 73/30 and none, one full drain");
    if (err_cnt == 0 && seg_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/gest_pkg.sv
sv/gest_sqr.sv
sv/gest_isqrt.sv
sv/gcode_extrusion_segment_tracker_top.sv
sv/gest_checker.sv
dv/gcode_extrusion_segment_tracker_top_test.sv
